// ===== sv/psme_pkg.sv =====
// Shared types and constants of the point set match evaluator.
`default_nettype none
package psme_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 20;
    localparam int CFG_W      = 20;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int DIST_W     = 2 * COORD_BITS + 2;  // dx^2 + dy^2 without loss
    localparam int SQ_W       = 2 * CFG_W;           // squared register value

    // Action codes
    localparam logic [1:0] ACT_REF  = 2'd0;
    localparam logic [1:0] ACT_MEAS = 2'd1;
    localparam logic [1:0] ACT_EVAL = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 2'd2;

    // Reset values of the registers
    localparam logic [CFG_W-1:0] RADIUS_RST = 20'd16;
    localparam logic [CFG_W-1:0] MARGIN_RST = 20'd0;
    localparam logic [CFG_W-1:0] GATE_RST   = 20'd16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_pt;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_in_beat;

    typedef struct packed {
        logic [CNT_W-1:0] reference_count;
        logic [CNT_W-1:0] measured_count;
        logic [CNT_W-1:0] matched;
        logic [CNT_W-1:0] fp_count;
        logic [CNT_W-1:0] fn_count;
        logic [CNT_W-1:0] excluded;
        logic [CFG_W-1:0] rmse;
        logic             passed;
        logic             overflowed;
    } t_out_beat;

endpackage
`default_nettype wire

// ===== sv/psme_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module psme_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/psme_dist.sv =====
// Pipelined squared distance unit shared by all evaluation passes.
`default_nettype none
module psme_dist (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire psme_pkg::t_pt                 i_a,
    input  wire psme_pkg::t_pt                 i_b,
    output logic                               o_done,
    output logic [psme_pkg::DIST_W-1:0]        o_dist
);

    localparam int DW = psme_pkg::COORD_BITS + 1;
    localparam int SW = 2 * DW;

    logic signed [DW-1:0] dx_s, dy_s;
    logic [DW-1:0]        r_dx, r_dy, r_dy2;
    logic [SW-1:0]        r_sqx, r_sqx2, r_sqy;
    logic [2:0]           r_vld;

    // Signed differences, widened by one bit
    assign dx_s = DW'(i_a.x) - DW'(i_b.x);
    assign dy_s = DW'(i_a.y) - DW'(i_b.y);

    // Valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_start};
            o_done <= r_vld[2];
        end
    end

    // Stage 1 abs diffs, stage 2 x square, stage 3 y square, stage 4 sum
    always_ff @(posedge i_clk) begin
        r_dx   <= dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
        r_dy   <= dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
        r_sqx  <= SW'(r_dx) * SW'(r_dx);
        r_dy2  <= r_dy;
        r_sqy  <= SW'(r_dy2) * SW'(r_dy2);
        r_sqx2 <= r_sqx;
        o_dist <= psme_pkg::DIST_W'(r_sqx2) + psme_pkg::DIST_W'(r_sqy);
    end

endmodule
`default_nettype wire

// ===== sv/psme_divsqrt.sv =====
// Iterative divider followed by an iterative integer square root.
`default_nettype none
module psme_divsqrt #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 11
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [NUM_W-1:0]           i_num,
    input  wire logic [DEN_W-1:0]           i_den,
    output logic                            o_done,
    output logic [psme_pkg::CFG_W-1:0]      o_root
);

    localparam int RW   = psme_pkg::CFG_W;
    localparam int QW   = 2 * RW;
    localparam int CNTW = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} t_state;

    t_state            r_state;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    r_rem;
    logic [RW+1:0]     r_srem;
    logic [CNTW-1:0]   r_cnt;

    logic [DEN_W:0]    rem_sh;
    logic              q_bit;
    logic [RW+1:0]     srem_sh, trial;
    logic              s_bit;

    // One quotient bit per cycle
    assign rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_den};

    // One root bit per cycle, quotient pairs taken from the top
    assign srem_sh = {r_srem[RW-1:0], r_num[QW-1:QW-2]};
    assign trial   = {o_root, 2'b01};
    assign s_bit   = srem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_rem   <= '0;
                        r_cnt   <= CNTW'(NUM_W);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? rem_sh - {1'b0, r_den} : rem_sh;
                    r_num <= {r_num[NUM_W-2:0], q_bit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_srem  <= '0;
                        o_root  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // Mean is below the squared radius, so it fits in QW bits
                    r_srem <= s_bit ? srem_sh - trial : srem_sh;
                    o_root <= {o_root[RW-2:0], s_bit};
                    r_num  <= {r_num[NUM_W-3:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(RW - 1)) begin
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/point_set_match_evaluator.sv =====
// Point set match evaluator: loader, evaluation sequencer and result register.
//
//  channel | direction | handshake                   | beat
//  in      | input     | i_in_valid / o_in_stall     | psme_pkg::t_in_beat
//  out     | output    | o_out_valid / i_out_stall   | psme_pkg::t_out_beat
//  cfg     | input     | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// A load beat leaves the FSM idle, so the input stays open for the next beat. An evaluate
// beat runs the single shared distance pipeline over all point pairs and then the serial
// divide and root; o_in_stall is high meanwhile and until the result beat leaves.
// Synchronous active low reset clears fills, overflow flag, registers and FSM;
// memories hold no reset value. The result beat holds until i_out_stall drops.
`default_nettype none
module point_set_match_evaluator #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire psme_pkg::t_in_beat                i_in_data,
    output logic                                   o_in_stall,
    output logic                                   o_out_valid,
    output psme_pkg::t_out_beat                    o_out_data,
    input  wire logic                              i_out_stall,
    input  wire logic                              i_cfg_we,
    input  wire logic [psme_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [psme_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int SW  = psme_pkg::SQ_W + CW;
    localparam int PW  = 2 * psme_pkg::COORD_BITS;
    localparam int DW  = psme_pkg::DIST_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CONST, ST_FIRST, ST_FIRST_W, ST_LAST_W,
        ST_T_RD, ST_T_W, ST_T_S0, ST_T_D0, ST_T_D1,
        ST_M_RD, ST_M_W, ST_M_RR, ST_M_RW, ST_M_D, ST_M_T, ST_M_TW,
        ST_F_RD, ST_F_W, ST_F_MR, ST_F_MW, ST_F_D, ST_F_NX,
        ST_P_MUL, ST_P_WAIT, ST_OUT
    } t_state;

    t_state                     r_state;
    logic [psme_pkg::CFG_W-1:0] r_radius, r_margin, r_gate;
    logic [psme_pkg::SQ_W-1:0]  r_r2, r_m2, r_g2;
    logic [1:0]                 r_k;
    logic [CW-1:0]              r_ref_fill, r_meas_fill, r_nr, r_nm;
    logic                       r_drop;
    logic [CW-1:0]              r_i, r_j;
    logic [CW-1:0]              r_matched, r_fp, r_fn, r_excl;
    logic [SW-1:0]              r_sum, r_gm;
    logic [DW-1:0]              r_best;
    logic [AW-1:0]              r_best_i;
    psme_pkg::t_pt              r_hold, r_first, r_last;
    logic                       r_d0le;

    logic                       in_acc;
    psme_pkg::t_pt              in_pt, ref_rd, meas_rd, dist_b;
    logic [PW-1:0]              ref_rdata, meas_rdata;
    logic [AW-1:0]              ref_raddr, trim_raddr;
    logic                       ref_we, meas_we, trim_we, trim_wbit, trim_rdata;
    logic [psme_pkg::CFG_W-1:0] cfg_sel;
    logic [psme_pkg::SQ_W-1:0]  cfg_sq;
    logic                       dist_start, dist_done;
    logic [DW-1:0]              dist_val;
    logic                       ds_start, ds_done;
    logic [psme_pkg::CFG_W-1:0] ds_root;
    logic                       trim_en, d_le_r2, last_i, last_j;

    // Input handshake and load writes
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_pt      = '{x: i_in_data.point_x, y: i_in_data.point_y};
    assign ref_we     = in_acc && (i_in_data.action == psme_pkg::ACT_REF)
                        && (r_ref_fill < CW'(MAX_POINTS));
    assign meas_we    = in_acc && (i_in_data.action == psme_pkg::ACT_MEAS)
                        && (r_meas_fill < CW'(MAX_POINTS));

    // Read address selection
    always_comb begin
        case (r_state)
            ST_FIRST:   ref_raddr = '0;
            ST_FIRST_W: ref_raddr = AW'(r_nr - 1'b1);
            default:    ref_raddr = r_i[AW-1:0];
        endcase
    end
    assign trim_raddr = (r_state == ST_M_T) ? r_best_i : r_i[AW-1:0];

    assign ref_rd  = psme_pkg::t_pt'(ref_rdata);
    assign meas_rd = psme_pkg::t_pt'(meas_rdata);

    psme_ram #(.W(PW), .D(MAX_POINTS)) u_ref_ram (
        .i_clk  (i_clk),
        .i_we   (ref_we),
        .i_waddr(r_ref_fill[AW-1:0]),
        .i_wdata(PW'(in_pt)),
        .i_raddr(ref_raddr),
        .o_rdata(ref_rdata)
    );

    psme_ram #(.W(PW), .D(MAX_POINTS)) u_meas_ram (
        .i_clk  (i_clk),
        .i_we   (meas_we),
        .i_waddr(r_meas_fill[AW-1:0]),
        .i_wdata(PW'(in_pt)),
        .i_raddr(r_j[AW-1:0]),
        .o_rdata(meas_rdata)
    );

    psme_ram #(.W(1), .D(MAX_POINTS)) u_trim_ram (
        .i_clk  (i_clk),
        .i_we   (trim_we),
        .i_waddr(r_i[AW-1:0]),
        .i_wdata(trim_wbit),
        .i_raddr(trim_raddr),
        .o_rdata(trim_rdata)
    );

    // Distance unit operands: held point against endpoint or memory data
    always_comb begin
        case (r_state)
            ST_T_S0: dist_b = r_first;
            ST_T_D0: dist_b = r_last;
            ST_M_RW: dist_b = ref_rd;
            default: dist_b = meas_rd;
        endcase
    end
    assign dist_start = (r_state == ST_T_S0) || (r_state == ST_M_RW)
                        || (r_state == ST_F_MW) || ((r_state == ST_T_D0) && dist_done);

    psme_dist u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(dist_start),
        .i_a    (r_hold),
        .i_b    (dist_b),
        .o_done (dist_done),
        .o_dist (dist_val)
    );

    // Trim decision and loop ends
    assign trim_en   = (r_margin != '0) && (r_nr >= CW'(2));
    assign trim_we   = (r_state == ST_T_D1) && dist_done;
    assign trim_wbit = trim_en && (r_d0le || (dist_val <= DW'(r_m2)));
    assign d_le_r2   = dist_val <= DW'(r_r2);
    assign last_i    = (r_i == r_nr - 1'b1);
    assign last_j    = (r_j == r_nm - 1'b1);

    // Register squares through one multiplier
    always_comb begin
        case (r_k)
            2'd0:    cfg_sel = r_radius;
            2'd1:    cfg_sel = r_margin;
            default: cfg_sel = r_gate;
        endcase
    end
    assign cfg_sq = psme_pkg::SQ_W'(cfg_sel) * psme_pkg::SQ_W'(cfg_sel);

    assign ds_start = (r_state == ST_P_MUL) && (r_matched != '0);

    psme_divsqrt #(.NUM_W(SW), .DEN_W(CW)) u_divsqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(ds_start),
        .i_num  (r_sum),
        .i_den  (r_matched),
        .o_done (ds_done),
        .o_root (ds_root)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= psme_pkg::RADIUS_RST;
            r_margin <= psme_pkg::MARGIN_RST;
            r_gate   <= psme_pkg::GATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psme_pkg::CFG_RADIUS: r_radius <= i_cfg_data;
                psme_pkg::CFG_MARGIN: r_margin <= i_cfg_data;
                psme_pkg::CFG_GATE:   r_gate   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ref_fill  <= '0;
            r_meas_fill <= '0;
            r_drop      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.action)
                            psme_pkg::ACT_REF: begin
                                if (ref_we) r_ref_fill <= r_ref_fill + 1'b1;
                                else        r_drop     <= 1'b1;
                            end
                            psme_pkg::ACT_MEAS: begin
                                if (meas_we) r_meas_fill <= r_meas_fill + 1'b1;
                                else         r_drop      <= 1'b1;
                            end
                            psme_pkg::ACT_EVAL: begin
                                r_nr      <= r_ref_fill;
                                r_nm      <= r_meas_fill;
                                r_matched <= '0;
                                r_fp      <= '0;
                                r_fn      <= '0;
                                r_excl    <= '0;
                                r_sum     <= '0;
                                r_k       <= '0;
                                r_state   <= ST_CONST;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CONST: begin
                    case (r_k)
                        2'd0:    r_r2 <= cfg_sq;
                        2'd1:    r_m2 <= cfg_sq;
                        default: r_g2 <= cfg_sq;
                    endcase
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        if (r_nr == '0) begin
                            // No references: every measured point is a false positive
                            r_fp    <= r_nm;
                            r_state <= ST_P_MUL;
                        end else begin
                            r_state <= ST_FIRST;
                        end
                    end
                end
                ST_FIRST:   r_state <= ST_FIRST_W;
                ST_FIRST_W: begin
                    r_first <= ref_rd;
                    r_state <= ST_LAST_W;
                end
                ST_LAST_W: begin
                    r_last  <= ref_rd;
                    r_i     <= '0;
                    r_state <= ST_T_RD;
                end
                // Trim pass over references
                ST_T_RD: r_state <= ST_T_W;
                ST_T_W: begin
                    r_hold  <= ref_rd;
                    r_state <= ST_T_S0;
                end
                ST_T_S0: r_state <= ST_T_D0;
                ST_T_D0: begin
                    if (dist_done) begin
                        r_d0le  <= dist_val <= DW'(r_m2);
                        r_state <= ST_T_D1;
                    end
                end
                ST_T_D1: begin
                    if (dist_done) begin
                        if (last_i) begin
                            r_j <= '0;
                            r_i <= '0;
                            r_state <= (r_nm == '0) ? ST_F_RD : ST_M_RD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_T_RD;
                        end
                    end
                end
                // Nearest reference for each measured point
                ST_M_RD: r_state <= ST_M_W;
                ST_M_W: begin
                    r_hold  <= meas_rd;
                    r_i     <= '0;
                    r_state <= ST_M_RR;
                end
                ST_M_RR: r_state <= ST_M_RW;
                ST_M_RW: r_state <= ST_M_D;
                ST_M_D: begin
                    if (dist_done) begin
                        if ((r_i == '0) || (dist_val < r_best)) begin
                            r_best   <= dist_val;
                            r_best_i <= r_i[AW-1:0];
                        end
                        if (last_i) begin
                            r_state <= ST_M_T;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_M_RR;
                        end
                    end
                end
                ST_M_T: r_state <= ST_M_TW;
                ST_M_TW: begin
                    if (trim_rdata) begin
                        r_excl <= r_excl + 1'b1;
                    end else if (r_best >= DW'(r_r2)) begin
                        r_fp <= r_fp + 1'b1;
                    end else begin
                        r_matched <= r_matched + 1'b1;
                        r_sum     <= r_sum + SW'(r_best);
                    end
                    if (last_j) begin
                        r_i     <= '0;
                        r_state <= ST_F_RD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_M_RD;
                    end
                end
                // Coverage pass over untrimmed references
                ST_F_RD: r_state <= ST_F_W;
                ST_F_W: begin
                    r_hold <= ref_rd;
                    if (trim_rdata) begin
                        r_state <= ST_F_NX;
                    end else if (r_nm == '0) begin
                        r_fn    <= r_fn + 1'b1;
                        r_state <= ST_F_NX;
                    end else begin
                        r_j     <= '0;
                        r_state <= ST_F_MR;
                    end
                end
                ST_F_MR: r_state <= ST_F_MW;
                ST_F_MW: r_state <= ST_F_D;
                ST_F_D: begin
                    if (dist_done) begin
                        if (d_le_r2) begin
                            r_state <= ST_F_NX;
                        end else if (last_j) begin
                            r_fn    <= r_fn + 1'b1;
                            r_state <= ST_F_NX;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_F_MR;
                        end
                    end
                end
                ST_F_NX: begin
                    if (last_i) begin
                        r_state <= ST_P_MUL;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_F_RD;
                    end
                end
                // Gate product, mean and root
                ST_P_MUL: begin
                    r_gm    <= SW'(r_g2) * SW'(r_matched);
                    r_state <= ST_P_WAIT;
                end
                ST_P_WAIT: begin
                    if ((r_matched == '0) || ds_done) begin
                        o_out_data.reference_count <= psme_pkg::CNT_W'(r_nr);
                        o_out_data.measured_count  <= psme_pkg::CNT_W'(r_nm);
                        o_out_data.matched         <= psme_pkg::CNT_W'(r_matched);
                        o_out_data.fp_count        <= psme_pkg::CNT_W'(r_fp);
                        o_out_data.fn_count        <= psme_pkg::CNT_W'(r_fn);
                        o_out_data.excluded        <= psme_pkg::CNT_W'(r_excl);
                        o_out_data.rmse            <= (r_matched != '0) ? ds_root : '0;
                        o_out_data.passed          <=
                            ((r_nr != '0) || (r_nm == '0)) && (r_fn == '0) && !r_drop
                            && ((r_matched != '0) ? (r_sum < r_gm) : (r_gate != '0));
                        o_out_data.overflowed      <= r_drop;
                        o_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_ref_fill  <= '0;
                        r_meas_fill <= '0;
                        r_drop      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // A pending result keeps the input closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while input open");

    // Every measured point lands in exactly one class
    a_class_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |->
            ((CW+2)'(r_matched) + (CW+2)'(r_fp) + (CW+2)'(r_excl) == (CW+2)'(r_nm)))
        else $error("measured point classes do not add up");

    // False negatives never outnumber references
    a_fn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_fn <= r_nr))
        else $error("false negative count too large");

    // Fills stay within capacity
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref_fill <= CW'(MAX_POINTS)) && (r_meas_fill <= CW'(MAX_POINTS)))
        else $error("fill beyond capacity");

    // Fills clear once the result beat leaves
    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (r_ref_fill == '0) && (r_meas_fill == '0))
        else $error("fills not cleared after result");
`endif

endmodule
`default_nettype wire
